/* rtl/crccc_pkg.sv */
package crccc_pkg;

  localparam int BYTE_W    = 8;
  localparam int NIBBLE_W  = 4;
  localparam int POLY_W    = 9;
  localparam int GLEN_W    = 4;
  localparam int TOTAL_W   = 32;
  localparam int TAKE_W    = 4;
  localparam int PAD_MAX   = 8;
  localparam int APB_W     = 32;
  localparam int CFG_AW    = 4;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] REG_POLY  = 2'd0;
  localparam logic [1:0] REG_GLEN  = 2'd1;
  localparam logic [1:0] REG_DSIZE = 2'd2;

  localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(13);
  localparam logic [GLEN_W-1:0] GLEN_RST = GLEN_W'(4);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   out_byte;
    logic [TOTAL_W-1:0]  codeword_total;
    logic [TOTAL_W-1:0]  error_total;
    logic                last;
  } result_t;

endpackage

/* rtl/crc_codeword_checker_unit.sv */
// A taken word is processed from the input register; its result enters the 2-entry result queue.
// Throughput: one word per cycle while the queue has room. A tlast word that also yields a data
//   byte is held again for its totals, as is a 4-bit-mode word closing two codewords while a nibble
//   waits. After a size change with many bits buffered, the bytes still due come out one per cycle.
//   While the queue is full the held word waits, also in the cycle that pops it.
// Reset: rst_n sync, active low; clears state and queue, restores poly 13, length 4, 4-bit data.
module crc_codeword_checker_unit #(
  parameter int MAX_GEN_LEN = 9,
  parameter int COUNT_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [crccc_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,   // end_of_stream
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [2*crccc_pkg::TOTAL_W+crccc_pkg::BYTE_W-1:0] out_tdata,
                    // [7:0] out_byte, [39:8] codeword_total, [71:40] error_total
  output logic                           out_tuser,  // kind
  output logic                           out_tlast,  // last
  // register port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [crccc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [crccc_pkg::APB_W-1:0]    cfg_pwdata,
  output logic [crccc_pkg::APB_W-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  // codeword up to 8 + G - 1 bits; buffer holds a leftover partial codeword plus one byte
  localparam int CW_W   = crccc_pkg::BYTE_W + MAX_GEN_LEN - 1;
  localparam int BUF_W  = CW_W - 1 + crccc_pkg::BYTE_W;
  localparam int FILL_W = $clog2(BUF_W + 1);
  localparam int LEN_W  = $clog2(CW_W + 1);
  localparam int GL_W   = $clog2(MAX_GEN_LEN + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [crccc_pkg::POLY_W-1:0] cfg_poly_r;
  logic [crccc_pkg::GLEN_W-1:0] cfg_glen_r;
  logic                         cfg_d8_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_poly_r <= crccc_pkg::POLY_RST;
      cfg_glen_r <= crccc_pkg::GLEN_RST;
      cfg_d8_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        crccc_pkg::REG_POLY:  cfg_poly_r <= cfg_pwdata[crccc_pkg::POLY_W-1:0];
        crccc_pkg::REG_GLEN:  cfg_glen_r <= cfg_pwdata[crccc_pkg::GLEN_W-1:0];
        crccc_pkg::REG_DSIZE: cfg_d8_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      crccc_pkg::REG_POLY:  cfg_prdata = crccc_pkg::APB_W'(cfg_poly_r);
      crccc_pkg::REG_GLEN:  cfg_prdata = crccc_pkg::APB_W'(cfg_glen_r);
      crccc_pkg::REG_DSIZE: cfg_prdata = crccc_pkg::APB_W'(cfg_d8_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Derived sizes: clamped generator length, masked generator, codeword length
  // ---------------------------------------------------------------------------
  logic [GL_W-1:0]        gl;
  logic [MAX_GEN_LEN-1:0] poly_ext;
  logic [MAX_GEN_LEN-1:0] gen;
  logic                   lead;
  logic [LEN_W-1:0]       cw_len;

  assign poly_ext = MAX_GEN_LEN'(cfg_poly_r);

  always_comb begin
    if (int'(cfg_glen_r) < 2)
      gl = GL_W'(2);
    else if (int'(cfg_glen_r) > MAX_GEN_LEN)
      gl = GL_W'(MAX_GEN_LEN);
    else
      gl = GL_W'(cfg_glen_r);
    lead = 1'b0;
    for (int i = 0; i < MAX_GEN_LEN; i++) begin
      gen[i] = poly_ext[i] & (i < int'(gl));
      lead   = lead | (poly_ext[i] & (i == int'(gl) - 1));
    end
    cw_len = (cfg_d8_r ? LEN_W'(crccc_pkg::BYTE_W) : LEN_W'(crccc_pkg::NIBBLE_W))
             + LEN_W'(gl) - LEN_W'(1);
  end

  // mod-2 long division; true when the remainder is nonzero
  function automatic logic rem_nz(input logic [CW_W-1:0]        cw_in,
                                  input logic [LEN_W-1:0]       ln,
                                  input logic [GL_W-1:0]        g,
                                  input logic [MAX_GEN_LEN-1:0] gp,
                                  input logic                   ld);
    logic [CW_W-1:0] r;
    logic [CW_W-1:0] m;
    r = cw_in;
    for (int i = CW_W - 1; i >= 0; i--) begin
      if (ld && i < int'(ln) && i >= int'(g) - 1 && r[i])
        r = r ^ (CW_W'(gp) << (i - (int'(g) - 1)));
    end
    m = CW_W'(((CW_W+1)'(1) << (g - GL_W'(1))) - (CW_W+1)'(1));
    return (r & m) != '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                         in_valid_r;
  logic [crccc_pkg::BYTE_W-1:0] in_byte_r;
  logic                         in_eos_r;
  logic                         consume;

  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Deframe state
  // ---------------------------------------------------------------------------
  logic                           pad_seen_r, pad_seen_nxt;
  logic [crccc_pkg::TAKE_W-1:0]   pad_skip_r, pad_skip_nxt;
  logic                           first_pend_r, first_pend_nxt;
  logic                           appended_r, appended_nxt;   // held word already shifted in
  logic [BUF_W-1:0]               buf_r, buf_nxt;
  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic [crccc_pkg::NIBBLE_W-1:0] packed_r, packed_nxt;
  logic                           half_r, half_nxt;
  logic [COUNT_BITS-1:0]          cw_cnt_r, cw_cnt_nxt;
  logic [COUNT_BITS-1:0]          err_cnt_r, err_cnt_nxt;

  logic [1:0] q_cnt_r;
  logic       proc;
  logic       push;
  crccc_pkg::result_t push_res;

  // per-cycle datapath: append the byte, then take up to two codewords
  logic [crccc_pkg::TAKE_W-1:0] take;
  logic [crccc_pkg::BYTE_W-1:0] byte_m;
  logic [BUF_W-1:0]             buf_a, buf_b, buf_c;
  logic [FILL_W-1:0]            fill_a, fill_b, fill_c;
  logic [CW_W-1:0]              len_mask, cw1, cw2;
  logic [crccc_pkg::BYTE_W-1:0] d_mask, dat1, dat2;
  logic                         cw1_ok, cw2_ok, out1, data_out, done;
  logic                         err1, err2;
  logic [COUNT_BITS-1:0]        cw_cnt_a, err_cnt_a;

  assign proc = in_valid_r && (q_cnt_r != 2'd2);

  always_comb begin
    take   = first_pend_r ? (crccc_pkg::TAKE_W'(crccc_pkg::PAD_MAX) - pad_skip_r)
                          : crccc_pkg::TAKE_W'(crccc_pkg::BYTE_W);
    byte_m = in_byte_r & crccc_pkg::BYTE_W'((9'h1 << take) - 9'h1);
    buf_a  = appended_r ? buf_r : ((buf_r << take) | BUF_W'(byte_m));
    fill_a = appended_r ? fill_r : (fill_r + FILL_W'(take));

    len_mask = CW_W'(((CW_W+1)'(1) << cw_len) - (CW_W+1)'(1));
    d_mask   = cfg_d8_r ? 8'hFF : 8'h0F;

    cw1_ok = fill_a >= FILL_W'(cw_len);
    cw1    = CW_W'(buf_a >> (fill_a - FILL_W'(cw_len))) & len_mask;
    dat1   = crccc_pkg::BYTE_W'(cw1 >> (gl - GL_W'(1))) & d_mask;
    err1   = rem_nz(cw1, cw_len, gl, gen, lead);
    fill_b = cw1_ok ? (fill_a - FILL_W'(cw_len)) : fill_a;
    buf_b  = buf_a & BUF_W'(((BUF_W+1)'(1) << fill_b) - (BUF_W+1)'(1));
    out1   = cw1_ok && (cfg_d8_r || half_r);

    // a second codeword only when the first one gave no byte
    cw2_ok = cw1_ok && !out1 && (fill_b >= FILL_W'(cw_len));
    cw2    = CW_W'(buf_b >> (fill_b - FILL_W'(cw_len))) & len_mask;
    dat2   = crccc_pkg::BYTE_W'(cw2 >> (gl - GL_W'(1))) & d_mask;
    err2   = rem_nz(cw2, cw_len, gl, gen, lead);
    fill_c = cw2_ok ? (fill_b - FILL_W'(cw_len)) : fill_b;
    buf_c  = buf_b & BUF_W'(((BUF_W+1)'(1) << fill_c) - (BUF_W+1)'(1));

    data_out = out1 || cw2_ok;
    done     = fill_c < FILL_W'(cw_len);

    // saturating totals
    cw_cnt_a  = (cw1_ok && cw_cnt_r != CNT_MAX) ? cw_cnt_r + 1'b1 : cw_cnt_r;
    err_cnt_a = (cw1_ok && err1 && err_cnt_r != CNT_MAX) ? err_cnt_r + 1'b1 : err_cnt_r;
  end

  always_comb begin
    pad_seen_nxt   = pad_seen_r;
    pad_skip_nxt   = pad_skip_r;
    first_pend_nxt = first_pend_r;
    appended_nxt   = appended_r;
    buf_nxt        = buf_r;
    fill_nxt       = fill_r;
    packed_nxt     = packed_r;
    half_nxt       = half_r;
    cw_cnt_nxt     = cw_cnt_r;
    err_cnt_nxt    = err_cnt_r;
    consume        = 1'b0;
    push           = 1'b0;
    push_res       = '0;

    if (proc) begin
      if (!pad_seen_r) begin
        pad_seen_nxt = 1'b1;
        pad_skip_nxt = (in_byte_r > crccc_pkg::BYTE_W'(crccc_pkg::PAD_MAX))
                     ? crccc_pkg::TAKE_W'(crccc_pkg::PAD_MAX)
                     : in_byte_r[crccc_pkg::TAKE_W-1:0];
        consume      = 1'b1;
        if (in_eos_r) begin
          push                    = 1'b1;
          push_res.kind           = crccc_pkg::KIND_TOTALS;
          push_res.codeword_total = crccc_pkg::TOTAL_W'(cw_cnt_r);
          push_res.error_total    = crccc_pkg::TOTAL_W'(err_cnt_r);
          push_res.last           = 1'b1;
        end
      end else begin
        first_pend_nxt = appended_r ? first_pend_r : 1'b0;
        buf_nxt        = buf_c;
        fill_nxt       = fill_c;
        cw_cnt_nxt     = (cw2_ok && cw_cnt_a != CNT_MAX) ? cw_cnt_a + 1'b1 : cw_cnt_a;
        err_cnt_nxt    = (cw2_ok && err2 && err_cnt_a != CNT_MAX)
                       ? err_cnt_a + 1'b1 : err_cnt_a;
        if (!cfg_d8_r) begin
          half_nxt = half_r ^ cw1_ok ^ cw2_ok;
          if (cw1_ok && !half_r && !cw2_ok)
            packed_nxt = dat1[crccc_pkg::NIBBLE_W-1:0];
        end
        // tlast word that also yields a byte: hold it again for the totals
        consume      = done && !(in_eos_r && data_out);
        appended_nxt = !consume;
        if (data_out) begin
          push          = 1'b1;
          push_res.kind = crccc_pkg::KIND_DATA;
          if (out1)
            push_res.out_byte = cfg_d8_r ? dat1 : {packed_r, dat1[crccc_pkg::NIBBLE_W-1:0]};
          else
            push_res.out_byte = {dat1[crccc_pkg::NIBBLE_W-1:0],
                                 dat2[crccc_pkg::NIBBLE_W-1:0]};
        end else if (done && in_eos_r) begin
          push                    = 1'b1;
          push_res.kind           = crccc_pkg::KIND_TOTALS;
          push_res.codeword_total = crccc_pkg::TOTAL_W'(cw_cnt_nxt);
          push_res.error_total    = crccc_pkg::TOTAL_W'(err_cnt_nxt);
          push_res.last           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_seen_r   <= 1'b0;
      pad_skip_r   <= '0;
      first_pend_r <= 1'b1;
      appended_r   <= 1'b0;
      buf_r        <= '0;
      fill_r       <= '0;
      packed_r     <= '0;
      half_r       <= 1'b0;
      cw_cnt_r     <= '0;
      err_cnt_r    <= '0;
    end else begin
      pad_seen_r   <= pad_seen_nxt;
      pad_skip_r   <= pad_skip_nxt;
      first_pend_r <= first_pend_nxt;
      appended_r   <= appended_nxt;
      buf_r        <= buf_nxt;
      fill_r       <= fill_nxt;
      packed_r     <= packed_nxt;
      half_r       <= half_nxt;
      cw_cnt_r     <= cw_cnt_nxt;
      err_cnt_r    <= err_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue, two entries
  // ---------------------------------------------------------------------------
  crccc_pkg::result_t q_r [2];
  logic               q_wp_r, q_rp_r;
  logic               pop;
  crccc_pkg::result_t head;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = q_cnt_r != 2'd0;
  assign head       = q_r[q_rp_r];
  assign out_tdata  = {head.error_total, head.codeword_total, head.out_byte};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
    end else begin
      if (push) q_wp_r <= !q_wp_r;
      if (pop)  q_rp_r <= !q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[q_wp_r] <= push_res;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= BUF_W)
    else $error("bit buffer fill past its width");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2) |-> !push)
    else $error("push into full result queue");

  a_err_le_cw: assert property (@(posedge clk) disable iff (!rst_n)
    err_cnt_r <= cw_cnt_r)
    else $error("error total above codeword total");

  a_pad_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !pad_seen_r) |=> (pad_seen_r && !appended_r))
    else $error("padding word not taken");

endmodule

/* tb/sv/testbench.sv */
module testbench;

  localparam int GEN_LEN_MAX   = 9;
  localparam int SETTLE_CYCLES = 6;     // word is registered before it is processed
  localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int RANDOM_PHASES = 17;
  localparam int PHASE_WORDS   = 50;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [crccc_pkg::BYTE_W-1:0]   in_tdata;   // [7:0] in_byte
  logic                           in_tlast;   // end_of_stream
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [2*crccc_pkg::TOTAL_W+crccc_pkg::BYTE_W-1:0] out_tdata;
                                              // [7:0] out_byte, [39:8] codeword_total,
                                              // [71:40] error_total
  logic                           out_tuser;  // kind
  logic                           out_tlast;  // last
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [crccc_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [crccc_pkg::APB_W-1:0]    cfg_pwdata;
  logic [crccc_pkg::APB_W-1:0]    cfg_prdata;
  logic                           cfg_pready;

  crc_codeword_checker_unit #(
    .MAX_GEN_LEN(GEN_LEN_MAX),
    .COUNT_BITS (crccc_pkg::TOTAL_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer mirror: stream state and register copies at the widths of the block
  // ---------------------------------------------------------------------------
  logic [crccc_pkg::POLY_W-1:0]  gen_poly   = crccc_pkg::POLY_RST;
  logic [crccc_pkg::GLEN_W-1:0]  gen_len    = crccc_pkg::GLEN_RST;
  logic                          wide_data  = 1'b0;     // 1: 8-bit datawords

  logic               pad_taken      = 1'b0;  // padding-count word consumed
  logic [3:0]         skip_bits      = '0;    // bits dropped from head of first data word
  logic               head_pending   = 1'b1;  // first data word not seen yet
  logic [31:0]        bit_pool       = '0;    // gathered stream bits, newest in LSBs
  int                 pool_fill      = 0;
  logic [3:0]         high_nibble    = '0;    // 4-bit dataword waiting for its partner
  logic               nibble_waiting = 1'b0;
  logic [crccc_pkg::TOTAL_W-1:0] cw_seen = '0;  // saturating codeword total
  logic [crccc_pkg::TOTAL_W-1:0] cw_bad  = '0;  // saturating error total

  crccc_pkg::result_t due_results[$];
  int                 bad_results = 0;

  // pacing: 0 = back to back, 1 = random gaps, 2 = mostly back to back
  int in_pace    = 1;
  int out_pace   = 1;
  int stall_left = 0;

  function automatic logic [31:0] ones(input int k);
    return (k >= 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
  endfunction

  function automatic int draw_wait(input int pace);
    if (pace == 0) return 0;
    if (pace == 2 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // length clamped into 2 .. GEN_LEN_MAX
  function automatic int active_gen_len();
    if (gen_len < 2) return 2;
    if (gen_len > GEN_LEN_MAX) return GEN_LEN_MAX;
    return int'(gen_len);
  endfunction

  // mod-2 long division; a generator with a zero top bit never subtracts
  function automatic bit syndrome_nonzero(input logic [31:0] cw, input int len, input int g);
    logic [crccc_pkg::POLY_W-1:0] gen;
    logic                         lead;
    gen  = gen_poly & crccc_pkg::POLY_W'(ones(g));
    lead = gen[g-1];
    for (int i = len - 1; i >= g - 1; i--)
      if (lead && cw[i]) cw = cw ^ (32'(gen) << (i - (g - 1)));
    return (cw & ones(g - 1)) != '0;
  endfunction

  task automatic push_data(input logic [7:0] value);
    crccc_pkg::result_t r;
    r = '0;
    r.kind     = crccc_pkg::KIND_DATA;
    r.out_byte = value;
    due_results.push_back(r);
  endtask

  // Feeds one accepted word through the mirror and queues what it yields.
  task automatic deframe_word(input logic [7:0] b, input logic eos);
    int                 take;
    int                 g;
    int                 d;
    int                 len;
    logic [31:0]        cw;
    logic [7:0]         dw;
    crccc_pkg::result_t r;
    if (!pad_taken) begin
      pad_taken = 1'b1;
      skip_bits = (b > 8'd8) ? 4'd8 : b[3:0];
    end else begin
      g    = active_gen_len();
      d    = wide_data ? 8 : 4;
      len  = d + g - 1;
      take = 8;
      if (head_pending) begin
        take         = 8 - int'(skip_bits);
        head_pending = 1'b0;
      end
      bit_pool  = (bit_pool << take) | (32'(b) & ones(take));
      pool_fill = pool_fill + take;
      // leftover bits shorter than a codeword simply stay in the pool
      while (pool_fill >= len) begin
        cw        = (bit_pool >> (pool_fill - len)) & ones(len);
        dw        = 8'((cw >> (g - 1)) & ones(d));
        pool_fill = pool_fill - len;
        bit_pool  = bit_pool & ones(pool_fill);
        if (cw_seen != '1) cw_seen = cw_seen + 1'b1;
        if (syndrome_nonzero(cw, len, g) && cw_bad != '1) cw_bad = cw_bad + 1'b1;
        if (d == 8) begin
          push_data(dw);
        end else if (!nibble_waiting) begin
          high_nibble    = dw[3:0];
          nibble_waiting = 1'b1;
        end else begin
          push_data({high_nibble, dw[3:0]});
          nibble_waiting = 1'b0;
        end
      end
    end
    if (eos) begin
      r = '0;
      r.kind           = crccc_pkg::KIND_TOTALS;
      r.codeword_total = cw_seen;
      r.error_total    = cw_bad;
      r.last           = 1'b1;
      due_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stream driver: one word per call, gap drawn up front, held until taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    gap = draw_wait(in_pace);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eos;
    do @(posedge clk); while (!in_tready);
    deframe_word(b, eos);
  endtask

  // Stop sending, let every queued result drain, then let the block settle in case
  // the last word is still in flight without a result.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, then read back on the same select.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      crccc_pkg::REG_POLY: begin
        gen_poly = value[crccc_pkg::POLY_W-1:0];
        stored   = 32'(value[crccc_pkg::POLY_W-1:0]);
      end
      crccc_pkg::REG_GLEN: begin
        gen_len = value[crccc_pkg::GLEN_W-1:0];
        stored  = 32'(value[crccc_pkg::GLEN_W-1:0]);
      end
      crccc_pkg::REG_DSIZE: begin
        wide_data = value[0];
        stored    = 32'(value[0]);
      end
      default: stored = '0;
    endcase
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== stored) begin
      bad_results++;
      if (bad_results <= 10)
        $display("%0t readback reg %0d: expected %08h got %08h", $time, idx, stored,
                 cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_generator(input logic [8:0] poly, input logic [3:0] glen,
                               input logic wide);
    wait_idle();
    write_reg(crccc_pkg::REG_POLY, 32'(poly));
    write_reg(crccc_pkg::REG_GLEN, 32'(glen));
    write_reg(crccc_pkg::REG_DSIZE, 32'(wide));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready follows a per-word stall count, every taken result is
  // compared against the oldest pending expectation
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready = (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    crccc_pkg::result_t got;
    crccc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      stall_left         = draw_wait(out_pace);
      got.kind           = out_tuser;
      got.out_byte       = out_tdata[7:0];
      got.codeword_total = out_tdata[39:8];
      got.error_total    = out_tdata[71:40];
      got.last           = out_tlast;
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t unexpected word: kind %0d byte %02h cw %0d err %0d last %0d",
                   $time, got.kind, got.out_byte, got.codeword_total, got.error_total,
                   got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          bad_results++;
          // fields in order kind/byte/cw/err/last
          if (bad_results <= 10)
            $display("%0t mismatch: expected %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
                     $time, want.kind, want.out_byte, want.codeword_total, want.error_total,
                     want.last, got.kind, got.out_byte, got.codeword_total,
                     got.error_total, got.last);
        end
      end
    end
  end

  // Watchdog: any transfer or register access resets the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Padding count above eight (drops the whole first data word) together with
  // end of stream on the padding word itself: totals of zero come out at once.
  task automatic test_padding_word();
    send_word(8'($urandom_range(9, 255)), 1'b1);
  endtask

  // Reset generator (1101, length 4, 4-bit datawords): all-zero and all-one
  // bytes, single bits at either end, alternating patterns, mid-stream end
  // markers and words after them.
  task automatic test_reset_generator();
    logic [7:0] pattern[12];
    logic       marker[12];
    pattern = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'hFF,
                8'h3C, 8'hC3};
    marker  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i < 12; i++) send_word(pattern[i], marker[i]);
  endtask

  // Generator corners. Each switch happens with bits still buffered, so the
  // new sizes cut the pool.
  task automatic test_generator_corners();
    // length below range clamps to 2; poly bits above it ignored
    set_generator(9'h1FF, 4'd0, 1'b1);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hFF, 1'b1);
    // length above range clamps to the maximum
    set_generator(9'h1FF, 4'd15, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h81, 1'b1);
    // top generator bit clear: remainder is just the tail bits
    set_generator(9'h00B, 4'd5, 1'b1);
    send_word(8'hF0, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hE7, 1'b1);
    // longest generator, single top bit
    set_generator(9'h100, 4'd9, 1'b0);
    send_word(8'h7E, 1'b0);
    send_word(8'h18, 1'b0);
    send_word(8'hDB, 1'b1);
  endtask

  // Random phases, each with its own register settings and pacing; the first
  // three pin the extreme settings.
  task automatic test_random_streams();
    logic [7:0] b;
    logic       eos;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_generator(9'h003, 4'd2, 1'b0);
        1:       set_generator(9'h1FF, 4'd9, 1'b1);
        2:       set_generator(9'h000, 4'd15, 1'b1);
        default: set_generator(9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)));
      endcase
      in_pace  = $urandom_range(0, 2);
      out_pace = $urandom_range(0, 2);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        eos = ($urandom_range(0, 15) == 0);
        send_word(b, eos);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_padding_word();
    test_reset_generator();
    test_generator_corners();
    test_random_streams();
    wait_idle();

    if (bad_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
